// File: src/rpn_stack_calculator_core_defines.svh
// assertion macros for the rpn stack calculator core
// no dependencies; included by modules that carry concurrent checks
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RPN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPN_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPN_ASSERT(label, clk, rst_n, prop, msg)
`define RPN_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: src/rpn_pkg.sv
// shared constants for the rpn stack calculator: action and status codes,
// field widths and parameter defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int ACTION_W  = 4;
    localparam int OPERAND_W = 32;
    localparam int SHOWN_W   = 32;
    localparam int STATUS_W  = 2;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_PUSH = 4'd0;
    localparam t_action ACT_ADD  = 4'd1;
    localparam t_action ACT_SUB  = 4'd2;
    localparam t_action ACT_MUL  = 4'd3;
    localparam t_action ACT_DIV  = 4'd4;
    localparam t_action ACT_REM  = 4'd5;
    localparam t_action ACT_POP  = 4'd6;
    localparam t_action ACT_PEEK = 4'd7;
    localparam t_action ACT_DUP  = 4'd8;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_UNDER   = 2'd1;
    localparam t_status ST_OVER    = 2'd2;
    localparam t_status ST_DIVZERO = 2'd3;

endpackage

`default_nettype wire

// File: src/rpn_stack_calculator_core.sv
// rpn stack calculator core: operand stack memory, sequencer and shared
// shift-add multiply / restoring divide unit; uses rpn_pkg and the defines header
//
// Reverse Polish integer calculator. One token is taken per transfer and
// processed alone; i_valid is taken only while o_stall is low. The operand
// stack is a single synchronous memory with a registered read port. Push
// writes at decode; pop/peek/dup read the top entry; the arithmetic actions
// read the top and then the second entry, and mul/div/rem then pass through
// the one-bit-per-cycle multiply/divide unit. Errors give one result.
// A finished result waits in the output register while the next token is
// taken. Unknown actions are dropped without a result.
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_calculator_core_defines.svh"

module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = rpn_pkg::DEF_VALUE_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [rpn_pkg::ACTION_W-1:0]        i_action,
    input  wire  signed [rpn_pkg::OPERAND_W-1:0] i_operand,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic signed [rpn_pkg::SHOWN_W-1:0]  o_shown_value,
    output logic [rpn_pkg::STATUS_W-1:0]        o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD1    = 3'd2;
    localparam logic [2:0] S_RD2    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_WB     = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [W-1:0] r_mem [STACK_DEPTH];
    logic [W-1:0] r_rd_data;

    logic [2:0]             r_state, n_state;
    logic [FW-1:0]          r_fill, n_fill;
    rpn_pkg::t_action       r_act, n_act;
    logic [W-1:0]           r_opnd, n_opnd;
    logic [W-1:0]           r_a, n_a;
    logic [W-1:0]           r_b, n_b;
    logic [W-1:0]           r_res, n_res;
    rpn_pkg::t_status       r_res_status, n_res_status;
    logic                   r_neg_q, n_neg_q;
    logic                   r_neg_r, n_neg_r;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_out_valid;
    logic [rpn_pkg::SHOWN_W-1:0] r_out_value;
    rpn_pkg::t_status       r_out_status;

    logic                   w_accept;
    logic                   w_out_load;
    logic                   w_we, w_re;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [W-1:0]           w_wdata;
    logic [FW-1:0]          w_fill_m1, w_fill_m2;
    logic                   w_full;
    logic [63:0]            w_op_ext;
    logic [63:0]            w_res_ext;
    logic [W:0]             w_div_shift, w_div_diff;
    logic                   w_div_ge;
    logic [W-1:0]           w_mul_sum;
    logic [W-1:0]           w_wb_val;

    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_out_load = (r_state == S_EMIT) && (!r_out_valid || !i_stall);
    assign w_fill_m1  = r_fill - FW'(1);
    assign w_fill_m2  = r_fill - FW'(2);
    assign w_full     = (r_fill >= FW'(STACK_DEPTH));
    assign w_op_ext   = 64'(i_operand);
    assign w_res_ext  = 64'(signed'(r_res));

    // restoring divide step: r_a shifts the dividend out and the quotient in
    assign w_div_shift = {r_res, r_a[W-1]};
    assign w_div_diff  = w_div_shift - {1'b0, r_b};
    assign w_div_ge    = !w_div_diff[W];

    assign w_mul_sum = r_res + (r_b[0] ? r_a : {W{1'b0}});

    always_comb begin
        case (r_act)
            rpn_pkg::ACT_DIV: w_wb_val = r_neg_q ? ({W{1'b0}} - r_a) : r_a;
            rpn_pkg::ACT_REM: w_wb_val = r_neg_r ? ({W{1'b0}} - r_res) : r_res;
            default:          w_wb_val = r_res;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_act        = r_act;
        n_opnd       = r_opnd;
        n_a          = r_a;
        n_b          = r_b;
        n_res        = r_res;
        n_res_status = r_res_status;
        n_neg_q      = r_neg_q;
        n_neg_r      = r_neg_r;
        n_cnt        = r_cnt;
        w_we         = 1'b0;
        w_waddr      = r_fill[AW-1:0];
        w_wdata      = r_opnd;
        w_re         = 1'b0;
        w_raddr      = w_fill_m1[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_act   = i_action;
                    n_opnd  = w_op_ext[W-1:0];
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res        = {W{1'b0}};
                n_res_status = rpn_pkg::ST_OK;
                case (r_act)
                    rpn_pkg::ACT_PUSH: begin
                        if (w_full) begin
                            n_res_status = rpn_pkg::ST_OVER;
                            n_state      = S_EMIT;
                        end else begin
                            w_we    = 1'b1;
                            n_fill  = r_fill + FW'(1);
                            n_state = S_IDLE;
                        end
                    end
                    rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL,
                    rpn_pkg::ACT_DIV, rpn_pkg::ACT_REM: begin
                        if (r_fill < FW'(2)) begin
                            n_res_status = rpn_pkg::ST_UNDER;
                            n_state      = S_EMIT;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_RD1;
                        end
                    end
                    rpn_pkg::ACT_POP, rpn_pkg::ACT_PEEK: begin
                        if (r_fill == '0) begin
                            n_res_status = rpn_pkg::ST_UNDER;
                            n_state      = S_EMIT;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_RD1;
                        end
                    end
                    rpn_pkg::ACT_DUP: begin
                        if (r_fill == '0) begin
                            n_res_status = rpn_pkg::ST_UNDER;
                            n_state      = S_EMIT;
                        end else if (w_full) begin
                            n_res_status = rpn_pkg::ST_OVER;
                            n_state      = S_EMIT;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_RD1;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD1: begin
                // top of stack is in r_rd_data
                n_b = r_rd_data;
                case (r_act)
                    rpn_pkg::ACT_POP: begin
                        n_res   = r_rd_data;
                        n_fill  = w_fill_m1;
                        n_state = S_EMIT;
                    end
                    rpn_pkg::ACT_PEEK: begin
                        n_res   = r_rd_data;
                        n_state = S_EMIT;
                    end
                    rpn_pkg::ACT_DUP: begin
                        w_we    = 1'b1;
                        w_wdata = r_rd_data;
                        n_fill  = r_fill + FW'(1);
                        n_state = S_IDLE;
                    end
                    default: begin
                        w_re    = 1'b1;
                        w_raddr = w_fill_m2[AW-1:0];
                        n_state = S_RD2;
                    end
                endcase
            end
            S_RD2: begin
                // second entry is in r_rd_data, top in r_b
                n_cnt = CW'(VALUE_WIDTH);
                case (r_act)
                    rpn_pkg::ACT_ADD: begin
                        n_res   = r_rd_data + r_b;
                        n_state = S_WB;
                    end
                    rpn_pkg::ACT_SUB: begin
                        n_res   = r_rd_data - r_b;
                        n_state = S_WB;
                    end
                    rpn_pkg::ACT_MUL: begin
                        n_a     = r_rd_data;
                        n_res   = {W{1'b0}};
                        n_state = S_MUL;
                    end
                    default: begin
                        if (r_b == '0) begin
                            n_res        = {W{1'b0}};
                            n_res_status = rpn_pkg::ST_DIVZERO;
                            n_state      = S_EMIT;
                        end else begin
                            n_a     = r_rd_data[W-1] ? ({W{1'b0}} - r_rd_data) : r_rd_data;
                            n_b     = r_b[W-1] ? ({W{1'b0}} - r_b) : r_b;
                            n_neg_q = r_rd_data[W-1] ^ r_b[W-1];
                            n_neg_r = r_rd_data[W-1];
                            n_res   = {W{1'b0}};
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                n_res = w_mul_sum;
                n_a   = {r_a[W-2:0], 1'b0};
                n_b   = {1'b0, r_b[W-1:1]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                n_res = w_div_ge ? w_div_diff[W-1:0] : w_div_shift[W-1:0];
                n_a   = {r_a[W-2:0], w_div_ge};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = w_fill_m2[AW-1:0];
                w_wdata = w_wb_val;
                n_fill  = w_fill_m1;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stack memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_opnd       <= n_opnd;
        r_a          <= n_a;
        r_b          <= n_b;
        r_res        <= n_res;
        r_res_status <= n_res_status;
        r_neg_q      <= n_neg_q;
        r_neg_r      <= n_neg_r;
        r_cnt        <= n_cnt;
        if (w_out_load) begin
            r_out_value  <= w_res_ext[rpn_pkg::SHOWN_W-1:0];
            r_out_status <= r_res_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_shown_value = signed'(r_out_value);
    assign o_status      = r_out_status;

    `RPN_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(STACK_DEPTH), "stack fill beyond depth")
    `RPN_ASSERT(a_err_zero, i_clk, i_rst_n, (o_valid && (o_status != rpn_pkg::ST_OK)) |-> (o_shown_value == '0), "error result with nonzero value")
    `RPN_ASSERT(a_push_fill, i_clk, i_rst_n, (r_state == S_DECODE && r_act == rpn_pkg::ACT_PUSH && !w_full) |=> (r_fill == $past(r_fill) + FW'(1)), "push did not grow the stack")
    `RPN_ASSERT(a_iter_cnt, i_clk, i_rst_n, (r_state == S_MUL || r_state == S_DIV) |-> (r_cnt != '0), "iterative unit ran past its count")

endmodule

`default_nettype wire

// File: dv/rpn_calc_checker.sv
// checker for the rpn stack calculator core: watches both channels, keeps its own
// operand stack to predict each display or fault status, and compares in order
// depends on rpn_pkg for action and status codes and the stack depth
`timescale 1ns / 1ps

module rpn_calc_checker
    import rpn_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        tok_valid,
    input  wire                        tok_stall,
    input  wire [ACTION_W-1:0]         tok_action,
    input  wire signed [OPERAND_W-1:0] tok_operand,
    input  wire                        res_valid,
    input  wire                        res_stall,
    input  wire signed [SHOWN_W-1:0]   res_value,
    input  wire [STATUS_W-1:0]         res_status,
    output int                         errors,
    output int                         waiting,
    output int                         checked,
    output int                         faulted
);

    localparam int DEPTH = DEF_STACK_DEPTH;

    typedef struct packed {
        logic signed [SHOWN_W-1:0] value;
        t_status                   status;
    } t_display;

    logic signed [OPERAND_W-1:0] calc_stack [DEPTH];
    int                          calc_fill;
    t_display                    display_queue [$];

    initial begin
        errors    = 0;
        waiting   = 0;
        checked   = 0;
        faulted   = 0;
        calc_fill = 0;
    end

    task automatic report_failure(input string msg);
        $display("[%0t] rpn checker: %s", $time, msg);
        errors++;
    endtask

    task automatic queue_display(input logic signed [SHOWN_W-1:0] value, input t_status status);
        t_display d;
        d.value  = value;
        d.status = status;
        display_queue.push_back(d);
    endtask

    // advance the shadow stack by one token and queue any display it causes
    task automatic apply_token(input t_action act, input logic signed [OPERAND_W-1:0] opnd);
        logic signed [OPERAND_W-1:0] top_v;
        logic signed [OPERAND_W-1:0] sec_v;
        logic signed [OPERAND_W-1:0] res;
        res = '0;
        case (act)
            ACT_PUSH: begin
                if (calc_fill >= DEPTH) begin
                    queue_display('0, ST_OVER);
                end else begin
                    calc_stack[calc_fill] = opnd;
                    calc_fill++;
                end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_REM: begin
                if (calc_fill < 2) begin
                    queue_display('0, ST_UNDER);
                end else begin
                    top_v = calc_stack[calc_fill-1];
                    sec_v = calc_stack[calc_fill-2];
                    if ((act == ACT_DIV || act == ACT_REM) && top_v == 0) begin
                        queue_display('0, ST_DIVZERO);
                    end else begin
                        case (act)
                            ACT_ADD: res = sec_v + top_v;
                            ACT_SUB: res = sec_v - top_v;
                            ACT_MUL: res = sec_v * top_v;
                            // division by minus one handled apart so the most
                            // negative value wraps instead of overflowing
                            ACT_DIV: res = (top_v == -1) ? 32'sd0 - sec_v : sec_v / top_v;
                            default: res = (top_v == -1) ? 32'sd0 : sec_v % top_v;
                        endcase
                        calc_fill--;
                        calc_stack[calc_fill-1] = res;
                    end
                end
            end
            ACT_POP: begin
                if (calc_fill == 0) begin
                    queue_display('0, ST_UNDER);
                end else begin
                    calc_fill--;
                    queue_display(calc_stack[calc_fill], ST_OK);
                end
            end
            ACT_PEEK: begin
                if (calc_fill == 0) queue_display('0, ST_UNDER);
                else queue_display(calc_stack[calc_fill-1], ST_OK);
            end
            ACT_DUP: begin
                if (calc_fill == 0) begin
                    queue_display('0, ST_UNDER);
                end else if (calc_fill >= DEPTH) begin
                    queue_display('0, ST_OVER);
                end else begin
                    calc_stack[calc_fill] = calc_stack[calc_fill-1];
                    calc_fill++;
                end
            end
            default: ;  // unknown codes are dropped
        endcase
    endtask

    always @(posedge clk) begin
        t_display want;
        if (rst_n) begin
            // results first: a token taken at this edge cannot have its result yet
            if (res_valid && !res_stall) begin
                checked++;
                if (res_status != ST_OK) faulted++;
                if (display_queue.size() == 0) begin
                    report_failure($sformatf("unexpected result value 0x%08h status %0d",
                        res_value, res_status));
                end else begin
                    want = display_queue.pop_front();
                    if (res_value !== want.value)
                        report_failure($sformatf("shown value expected 0x%08h, got 0x%08h",
                            want.value, res_value));
                    if (res_status !== want.status)
                        report_failure($sformatf("status expected %0d, got %0d",
                            want.status, res_status));
                end
            end
            if (tok_valid && !tok_stall) apply_token(tok_action, tok_operand);
            waiting = display_queue.size();
        end
    end

endmodule

// File: dv/tb_rpn_stack_calculator_core.sv
// testbench top for the rpn stack calculator core: clock, reset, token stimulus
// with sender idling and receiver stalls; depends on rpn_pkg, the core and rpn_calc_checker
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_core;
    import rpn_pkg::*;

    localparam t_action ACT_UNUSED_LO = 4'd9;
    localparam t_action ACT_UNUSED_HI = 4'd15;
    localparam logic signed [OPERAND_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [OPERAND_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int PHASE_TOKENS = 342;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;   // beyond the longest divide latency

    typedef enum int { BURST_FILL, BURST_DRAIN, BURST_MIX } t_burst;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [ACTION_W-1:0]         i_action;
    logic signed [OPERAND_W-1:0] i_operand;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [SHOWN_W-1:0]   o_shown_value;
    logic [STATUS_W-1:0]         o_status;

    int errors, waiting, checked, faulted;
    int sender_idle_pct, receiver_stall_pct;
    int tokens_counted, unknown_sent;
    bit hold_request;

    rpn_stack_calculator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_operand     (i_operand),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_shown_value (o_shown_value),
        .o_status      (o_status)
    );

    rpn_calc_checker u_checker (
        .clk         (i_clk),
        .rst_n       (i_rst_n),
        .tok_valid   (i_valid),
        .tok_stall   (o_stall),
        .tok_action  (i_action),
        .tok_operand (i_operand),
        .res_valid   (o_valid),
        .res_stall   (i_stall),
        .res_value   (o_shown_value),
        .res_status  (o_status),
        .errors      (errors),
        .waiting     (waiting),
        .checked     (checked),
        .faulted     (faulted)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_rpn_stack_calculator_core: done, errors");
        $finish;
    end

    // result side: random stalls plus one long hold-off once asked for
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    function automatic logic signed [OPERAND_W-1:0] pick_operand();
        case ($urandom_range(9))
            0, 1, 2: return $signed($urandom_range(8)) - 32'sd4;
            3:       return VAL_MIN;
            4:       return VAL_MAX;
            5:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_action pick_action(input int push_pct);
        int r;
        if ($urandom_range(99) < push_pct) return ACT_PUSH;
        r = $urandom_range(99);
        if (r < 55) return t_action'($urandom_range(ACT_REM, ACT_ADD));
        if (r < 72) return ACT_POP;
        if (r < 84) return ACT_PEEK;
        if (r < 95) return ACT_DUP;
        return t_action'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_token(input t_action act, input logic signed [OPERAND_W-1:0] opnd);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_operand <= opnd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (act > ACT_DUP) unknown_sent++;
        else tokens_counted++;
    endtask

    task automatic run_burst(input t_burst kind);
        int n;
        case (kind)
            BURST_FILL: begin
                // enough pushes and dups to fill from any level, then both overflow paths
                repeat (17) send_token(($urandom_range(3) == 0) ? ACT_DUP : ACT_PUSH,
                    pick_operand());
                send_token(ACT_PUSH, pick_operand());
                send_token(ACT_DUP, pick_operand());
            end
            BURST_DRAIN: begin
                n = $urandom_range(20, 6);
                repeat (n) send_token(pick_action(10), pick_operand());
            end
            default: begin
                n = $urandom_range(30, 10);
                repeat (n) send_token(pick_action(40), pick_operand());
            end
        endcase
    endtask

    initial begin
        int target;
        t_burst kind;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_action           = ACT_PUSH;
        i_operand          = '0;
        hold_request       = 1'b0;
        tokens_counted     = 0;
        unknown_sent       = 0;
        sender_idle_pct    = 26;
        receiver_stall_pct = 69;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack and single-entry underflow
        send_token(ACT_POP, $urandom);
        send_token(ACT_PEEK, $urandom);
        send_token(ACT_DUP, $urandom);
        send_token(ACT_SUB, $urandom);
        send_token(ACT_PUSH, VAL_MAX);
        send_token(ACT_REM, $urandom);
        // wrap on add, then most negative divided by minus one
        send_token(ACT_PUSH, 32'sd1);
        send_token(ACT_ADD, $urandom);
        send_token(ACT_DUP, $urandom);
        send_token(ACT_PUSH, -32'sd1);
        send_token(ACT_DIV, $urandom);
        send_token(ACT_PUSH, -32'sd1);
        send_token(ACT_REM, $urandom);
        // divide by zero keeps both entries
        send_token(ACT_DIV, $urandom);
        send_token(ACT_REM, $urandom);
        send_token(ACT_POP, $urandom);
        // remainder sign follows the second entry
        send_token(ACT_PUSH, -32'sd7);
        send_token(ACT_PUSH, 32'sd2);
        send_token(ACT_REM, $urandom);
        send_token(ACT_MUL, $urandom);
        send_token(ACT_PEEK, $urandom);
        send_token(ACT_PUSH, VAL_MAX);
        send_token(ACT_MUL, $urandom);
        send_token(ACT_UNUSED_HI, $urandom);
        send_token(ACT_POP, $urandom);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin sender_idle_pct = 26; receiver_stall_pct = 69; end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 26; end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    hold_request       = 1'b1;
                end
            endcase
            target = tokens_counted + PHASE_TOKENS;
            kind   = BURST_FILL;
            while (tokens_counted < target) begin
                run_burst(kind);
                kind = t_burst'($urandom_range(2));
            end
        end
        i_valid <= 1'b0;

        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d tokens plus %0d unknown codes over three stall mixes",
            tokens_counted, unknown_sent);
        $display("%0d results compared, %0d of them fault statuses", checked, faulted);
        if (errors == 0 && waiting == 0) begin
            $display("tb_rpn_stack_calculator_core: done, clean");
        end else begin
            $display("tb_rpn_stack_calculator_core: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/rpn_pkg.sv
src/rpn_stack_calculator_core.sv
dv/rpn_calc_checker.sv
dv/tb_rpn_stack_calculator_core.sv
